/* src/sine_cosine_taylor_assert.svh */
`ifndef SINE_COSINE_TAYLOR_ASSERT_SVH
`define SINE_COSINE_TAYLOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sct_pkg.sv */
package sct_pkg;

	localparam int IFRAC = 30;

	localparam logic FUNC_SIN = 1'b0;
	localparam logic FUNC_COS = 1'b1;

	localparam logic [33:0] ONE_Q30    = 34'd1073741824;
	localparam logic [31:0] HALF_Q30   = 32'd536870912;
	localparam logic [25:0] PI_Q24     = 26'd52707179;
	localparam logic [26:0] TWO_PI_Q24 = 27'd105414358;
	localparam logic [31:0] RED_OFFSET = 32'd2213701518;
	localparam logic [13:0] RED_RECIP  = 14'd10430;
	localparam logic [31:0] DIV3_RECIP = 32'hAAAAAAAB;

	typedef struct packed {
		logic               cos;
		logic               flip;
		logic [31:0]        a2;
		logic signed [33:0] sum;
	} side_t;

	function automatic logic [8:0] term_div(input logic cosine, input logic [2:0] k);
		logic [8:0] dc;
		logic [8:0] ds;
		case (k)
			3'd0: begin dc = 9'd2;   ds = 9'd6;   end
			3'd1: begin dc = 9'd12;  ds = 9'd20;  end
			3'd2: begin dc = 9'd30;  ds = 9'd42;  end
			3'd3: begin dc = 9'd56;  ds = 9'd72;  end
			3'd4: begin dc = 9'd90;  ds = 9'd110; end
			3'd5: begin dc = 9'd132; ds = 9'd156; end
			3'd6: begin dc = 9'd182; ds = 9'd210; end
			default: begin dc = 9'd240; ds = 9'd272; end
		endcase
		return cosine ? dc : ds;
	endfunction

	function automatic logic [31:0] term_recip(input logic cosine, input logic [2:0] k);
		logic [31:0] rc;
		logic [31:0] rs;
		case (k)
			3'd0: begin rc = 32'd2147483648; rs = 32'd715827882; end
			3'd1: begin rc = 32'd357913941;  rs = 32'd214748364; end
			3'd2: begin rc = 32'd143165576;  rs = 32'd102261126; end
			3'd3: begin rc = 32'd76695844;   rs = 32'd59652323;  end
			3'd4: begin rc = 32'd47721858;   rs = 32'd39045157;  end
			3'd5: begin rc = 32'd32537631;   rs = 32'd27531841;  end
			3'd6: begin rc = 32'd23598721;   rs = 32'd20452225;  end
			default: begin rc = 32'd17895697; rs = 32'd15790320; end
		endcase
		return cosine ? rc : rs;
	endfunction

endpackage

/* src/sct_qdiv.sv */
module sct_qdiv import sct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x,
	input  logic [8:0]  d,
	input  logic [31:0] recip,
	input  side_t       side_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] q,
	output side_t       side_out
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        en1, en2, en3, en4;
	logic [32:0] y_s1, y_s2, y_s3;
	logic [8:0]  d_s1, d_s2, d_s3;
	logic [31:0] r_s1;
	logic [31:0] q_s2, q_s3, q_s4;
	logic [40:0] qd_s3;
	side_t       side_s1, side_s2, side_s3, side_s4;
	logic [64:0] p_c;
	logic [32:0] rem_c;

	assign en4 = ~v_s4 | out_ready;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign in_ready = en1;

	assign p_c   = 65'(y_s1) * 65'(r_s1);
	assign rem_c = y_s3 - qd_s3[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			y_s1    <= 33'(x) + 33'(d[8:1]);
			d_s1    <= d;
			r_s1    <= recip;
			side_s1 <= side_in;
		end
		if (en2) begin
			q_s2    <= p_c[63:32];
			y_s2    <= y_s1;
			d_s2    <= d_s1;
			side_s2 <= side_s1;
		end
		if (en3) begin
			qd_s3   <= 41'(q_s2) * 41'(d_s2);
			q_s3    <= q_s2;
			y_s3    <= y_s2;
			d_s3    <= d_s2;
			side_s3 <= side_s2;
		end
		if (en4) begin
			q_s4    <= q_s3 + 32'(rem_c >= 33'(d_s3));
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign q         = q_s4;
	assign side_out  = side_s4;

endmodule

/* src/sine_cosine_taylor.sv */
// channel | dir | tdata                 | tuser
// s_*     | in  | theta[31:0] Q8.24     | func (0 sine, 1 cosine)
// m_*     | out | value[31:0] signed    | -
//
// One transaction per cycle sustained while m_tready stays high. Each term
// runs a multiply stage and a four-stage constant divider. arst_n clears
// only the valid bits. A stall at m_tready holds each occupied stage whose
// later stages are all full; empty stages still fill, so s_tready stays
// high until the pipeline is full.
module sine_cosine_taylor import sct_pkg::*; #(
	parameter int TERMS            = 7,
	parameter int RESULT_FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] theta
	input  logic        s_tuser,  // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] value
);

	localparam int          SH   = IFRAC - RESULT_FRAC_BITS;
	localparam logic [30:0] RND  = (31'd1 << SH) >> 1;
	localparam logic [30:0] LIM  = 31'd1 << RESULT_FRAC_BITS;
	localparam int          NQ   = TERMS - 1;
	localparam bit          SUBF = ((TERMS - 1) % 2) == 1;

	function automatic logic [31:0] qmul(input logic [31:0] x, input logic [31:0] y);
		logic [63:0] p;
		p = 64'(x) * 64'(y) + 64'(HALF_Q30);
		return p[IFRAC+31:IFRAC];
	endfunction

	// front end: range reduction and divide by three
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic        en1, en2, en3, en4, en5, en6, en7, en8, en9;
	logic        cos_s1, cos_s2, cos_s3, cos_s4, cos_s5, cos_s6, cos_s7, cos_s8;
	logic        flip_s6, flip_s7, flip_s8;
	logic [32:0] u_s1, u_s2, u_s3;
	logic [5:0]  q_s2;
	logic [32:0] qd_s3;
	logic [27:0] r_s4;
	logic [26:0] r_s5;
	logic [31:0] x_s6;
	logic [30:0] a_s7, a_s8;
	logic [31:0] a2_s8;
	logic [31:0] x_s9;
	side_t       side_s9;

	logic signed [33:0] u_c;
	logic [46:0]        p2_c;
	logic [32:0]        d4_c;
	logic               fl_c;
	logic [25:0]        r6_c;
	logic [63:0]        p7_c;

	logic        q0_rdy;
	logic        qv   [NQ];
	logic        qrdy [NQ];
	logic [31:0] qmag [NQ];
	side_t       qside[NQ];

	assign u_c  = {{2{s_tdata[31]}}, s_tdata} + $signed({2'b00, RED_OFFSET});
	assign p2_c = 47'(u_s1) * 47'(RED_RECIP);
	assign d4_c = u_s3 - qd_s3;
	assign fl_c = r_s5 > 27'(PI_Q24);
	assign r6_c = fl_c ? 26'(r_s5 - 27'(PI_Q24)) : r_s5[25:0];
	assign p7_c = 64'(x_s6) * 64'(DIV3_RECIP);

	assign en9 = ~v_s9 | q0_rdy;
	assign en8 = ~v_s8 | en9;
	assign en7 = ~v_s7 | en8;
	assign en6 = ~v_s6 | en7;
	assign en5 = ~v_s5 | en6;
	assign en4 = ~v_s4 | en5;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
			if (en9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cos_s1 <= (s_tuser == FUNC_COS);
			u_s1   <= u_c[32:0];
		end
		if (en2) begin
			cos_s2 <= cos_s1;
			u_s2   <= u_s1;
			q_s2   <= p2_c[45:40];
		end
		if (en3) begin
			cos_s3 <= cos_s2;
			u_s3   <= u_s2;
			qd_s3  <= 33'(q_s2) * 33'(TWO_PI_Q24);
		end
		if (en4) begin
			cos_s4 <= cos_s3;
			r_s4   <= d4_c[27:0];
		end
		if (en5) begin
			cos_s5 <= cos_s4;
			r_s5   <= (r_s4 >= 28'(TWO_PI_Q24)) ? 27'(r_s4 - 28'(TWO_PI_Q24)) : r_s4[26:0];
		end
		if (en6) begin
			cos_s6  <= cos_s5;
			flip_s6 <= fl_c;
			x_s6    <= {r6_c, 6'd1};
		end
		if (en7) begin
			cos_s7  <= cos_s6;
			flip_s7 <= flip_s6;
			a_s7    <= p7_c[63:33];
		end
		if (en8) begin
			cos_s8  <= cos_s7;
			flip_s8 <= flip_s7;
			a_s8    <= a_s7;
			a2_s8   <= qmul(32'(a_s7), 32'(a_s7));
		end
		if (en9) begin
			x_s9         <= cos_s8 ? a2_s8 : qmul(32'(a_s8), a2_s8);
			side_s9.cos  <= cos_s8;
			side_s9.flip <= flip_s8;
			side_s9.a2   <= a2_s8;
			side_s9.sum  <= cos_s8 ? $signed(ONE_Q30) : $signed(34'(a_s8));
		end
	end

	sct_qdiv u_qdiv0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_ready (q0_rdy),
		.x        (x_s9),
		.d        (term_div(side_s9.cos, 3'd0)),
		.recip    (term_recip(side_s9.cos, 3'd0)),
		.side_in  (side_s9),
		.out_valid(qv[0]),
		.out_ready(qrdy[0]),
		.q        (qmag[0]),
		.side_out (qside[0])
	);

	// series terms: accumulate, multiply by a^2, divide by n(n+1)
	for (genvar k = 1; k < NQ; k++) begin : g_term
		localparam bit SUB = (k % 2) == 1;
		logic        v_s1;
		logic        en;
		logic        qin_rdy;
		logic [31:0] x_s1;
		side_t       side_s1;
		logic signed [33:0] sum_c;

		assign en      = ~v_s1 | qin_rdy;
		assign qrdy[k-1] = en;
		assign sum_c   = SUB ? qside[k-1].sum - $signed({2'b00, qmag[k-1]})
		                     : qside[k-1].sum + $signed({2'b00, qmag[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
			end else if (en) begin
				v_s1 <= qv[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1         <= qmul(qmag[k-1], qside[k-1].a2);
				side_s1.cos  <= qside[k-1].cos;
				side_s1.flip <= qside[k-1].flip;
				side_s1.a2   <= qside[k-1].a2;
				side_s1.sum  <= sum_c;
			end
		end

		sct_qdiv u_qdiv (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_s1),
			.in_ready (qin_rdy),
			.x        (x_s1),
			.d        (term_div(side_s1.cos, 3'(k))),
			.recip    (term_recip(side_s1.cos, 3'(k))),
			.side_in  (side_s1),
			.out_valid(qv[k]),
			.out_ready(qrdy[k]),
			.q        (qmag[k]),
			.side_out (qside[k])
		);
	end

	// back end: last term, triple angle, sign and output scaling
	logic        bk_v_s1, bk_v_s2, bk_v_s3, bk_v_s4, bk_v_s5, bk_v_s6, bk_v_s7, bk_v_s8;
	logic        ben1, ben2, ben3, ben4, ben5, ben6, ben7, ben8;
	logic        bk_cos_s1, bk_cos_s2, bk_cos_s3;
	logic        bk_flip_s1, bk_flip_s2, bk_flip_s3, bk_flip_s4;
	logic [31:0] bk_s_s1, bk_s_s2, bk_s_s3;
	logic [31:0] bk_ss_s2, bk_cube_s3;
	logic signed [35:0] bk_res_s4;
	logic signed [31:0] bk_res_s5;
	logic        bk_neg_s6, bk_neg_s7;
	logic [30:0] bk_mag_s6, bk_mag_s7;
	logic [31:0] bk_val_s8;

	logic signed [33:0] sumf_c;
	logic signed [35:0] c4_c, t3_c, res_c;
	logic signed [31:0] cl_c;
	logic [30:0]        rnd_c, sat_c;

	assign ben8 = ~bk_v_s8 | m_tready;
	assign ben7 = ~bk_v_s7 | ben8;
	assign ben6 = ~bk_v_s6 | ben7;
	assign ben5 = ~bk_v_s5 | ben6;
	assign ben4 = ~bk_v_s4 | ben5;
	assign ben3 = ~bk_v_s3 | ben4;
	assign ben2 = ~bk_v_s2 | ben3;
	assign ben1 = ~bk_v_s1 | ben2;
	assign qrdy[NQ-1] = ben1;

	assign sumf_c = SUBF ? qside[NQ-1].sum - $signed({2'b00, qmag[NQ-1]})
	                     : qside[NQ-1].sum + $signed({2'b00, qmag[NQ-1]});
	assign c4_c  = $signed({2'b00, bk_cube_s3, 2'b00});
	assign t3_c  = $signed({4'b0000, bk_s_s3}) + $signed({3'b000, bk_s_s3, 1'b0});
	assign res_c = bk_cos_s3 ? c4_c - t3_c : t3_c - c4_c;
	assign cl_c  = (bk_res_s4 > $signed(36'(ONE_Q30))) ? $signed(32'(ONE_Q30)) :
	               (bk_res_s4 < -$signed(36'(ONE_Q30))) ? -$signed(32'(ONE_Q30)) :
	               32'(bk_res_s4);
	assign rnd_c = bk_mag_s6 + RND;
	assign sat_c = (bk_mag_s7 > LIM) ? LIM : bk_mag_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_v_s1 <= 1'b0;
			bk_v_s2 <= 1'b0;
			bk_v_s3 <= 1'b0;
			bk_v_s4 <= 1'b0;
			bk_v_s5 <= 1'b0;
			bk_v_s6 <= 1'b0;
			bk_v_s7 <= 1'b0;
			bk_v_s8 <= 1'b0;
		end else begin
			if (ben1) bk_v_s1 <= qv[NQ-1];
			if (ben2) bk_v_s2 <= bk_v_s1;
			if (ben3) bk_v_s3 <= bk_v_s2;
			if (ben4) bk_v_s4 <= bk_v_s3;
			if (ben5) bk_v_s5 <= bk_v_s4;
			if (ben6) bk_v_s6 <= bk_v_s5;
			if (ben7) bk_v_s7 <= bk_v_s6;
			if (ben8) bk_v_s8 <= bk_v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ben1) begin
			bk_cos_s1  <= qside[NQ-1].cos;
			bk_flip_s1 <= qside[NQ-1].flip;
			bk_s_s1    <= sumf_c[33] ? 32'd0 : sumf_c[31:0];
		end
		if (ben2) begin
			bk_cos_s2  <= bk_cos_s1;
			bk_flip_s2 <= bk_flip_s1;
			bk_s_s2    <= bk_s_s1;
			bk_ss_s2   <= qmul(bk_s_s1, bk_s_s1);
		end
		if (ben3) begin
			bk_cos_s3  <= bk_cos_s2;
			bk_flip_s3 <= bk_flip_s2;
			bk_s_s3    <= bk_s_s2;
			bk_cube_s3 <= qmul(bk_ss_s2, bk_s_s2);
		end
		if (ben4) begin
			bk_flip_s4 <= bk_flip_s3;
			bk_res_s4  <= res_c;
		end
		if (ben5) begin
			bk_res_s5 <= bk_flip_s4 ? -cl_c : cl_c;
		end
		if (ben6) begin
			bk_neg_s6 <= bk_res_s5[31];
			bk_mag_s6 <= bk_res_s5[31] ? 31'(-bk_res_s5) : bk_res_s5[30:0];
		end
		if (ben7) begin
			bk_neg_s7 <= bk_neg_s6;
			bk_mag_s7 <= rnd_c >> SH;
		end
		if (ben8) begin
			bk_val_s8 <= bk_neg_s7 ? -{1'b0, sat_c} : {1'b0, sat_c};
		end
	end

	assign m_tvalid = bk_v_s8;
	assign m_tdata  = bk_val_s8;

endmodule

/* src/sct_checker.sv */
`include "sine_cosine_taylor_assert.svh"

module sct_checker #(
	parameter int RESULT_FRAC_BITS = 30
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	localparam logic signed [32:0] LIM = 33'sd1 <<< RESULT_FRAC_BITS;

	`SCT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
	`SCT_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed under stall")
	`SCT_ASSERT_NOW(a_ready_flow, clk, arst_n, m_tready, s_tready, "input stalled while output drains")
	`SCT_ASSERT_NOW(a_range, clk, arst_n, m_tvalid, ($signed({m_tdata[31], m_tdata}) <= LIM) && ($signed({m_tdata[31], m_tdata}) >= -LIM), "result beyond unit range")

endmodule

bind sine_cosine_taylor sct_checker #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_sct_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
